// ----- rtl/dtt_pkg.sv -----
`default_nettype none
package dtt_pkg;

  localparam int unsigned FRACTION_DIGITS = 9;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [2:0] KIND_DATE     = 3'd0;
  localparam logic [2:0] KIND_TIME     = 3'd1;
  localparam logic [2:0] KIND_TS       = 3'd2;
  localparam logic [2:0] KIND_TS_LOCAL = 3'd3;
  localparam logic [2:0] KIND_TS_ZONE  = 3'd4;

  localparam logic [1:0] TYPE_DATE  = 2'd0;
  localparam logic [1:0] TYPE_TIME  = 2'd1;
  localparam logic [1:0] TYPE_TS    = 2'd2;
  localparam logic [1:0] TYPE_TS_TZ = 2'd3;

  localparam logic [63:0] SAT_LIMIT    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_DIV10    = 64'd922337203685477580;
  localparam logic [63:0] DAY_SHIFT    = 64'd10957;
  localparam logic [63:0] SECOND_SHIFT = 64'd946684800;
  localparam logic [19:0] MICROS_PER_S = 20'd1000000;
  localparam logic [29:0] ROUND_HALF   = 30'd500;
  localparam logic [9:0]  THOUSAND     = 10'd1000;
  localparam logic [30:0] RECIP_1000   = 31'd1099511627;
  localparam int unsigned RECIP_SHIFT  = 40;

  typedef enum logic [1:0] {
    PH_START,
    PH_LEAD,
    PH_WHOLE,
    PH_FRAC
  } phase_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        whole_neg;
    logic        first_minus;
    logic [29:0] frac;
    logic [3:0]  cnt;
    logic [2:0]  kind;
  } dtt_rec_t;

  function automatic logic [29:0] pad_scale(input logic [3:0] cnt);
    case (cnt)
      4'd0:    pad_scale = 30'd1000000000;
      4'd1:    pad_scale = 30'd100000000;
      4'd2:    pad_scale = 30'd10000000;
      4'd3:    pad_scale = 30'd1000000;
      4'd4:    pad_scale = 30'd100000;
      4'd5:    pad_scale = 30'd10000;
      4'd6:    pad_scale = 30'd1000;
      4'd7:    pad_scale = 30'd100;
      4'd8:    pad_scale = 30'd10;
      default: pad_scale = 30'd1;
    endcase
  endfunction

  function automatic logic [1:0] kind_to_type(input logic [2:0] kind);
    case (kind)
      KIND_DATE: kind_to_type = TYPE_DATE;
      KIND_TIME: kind_to_type = TYPE_TIME;
      KIND_TS:   kind_to_type = TYPE_TS;
      default:   kind_to_type = TYPE_TS_TZ;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/decimal_time_text_to_microseconds.sv -----
`default_nettype none
// channel   dir  tdata                       tuser             tlast
// s_axis    in   [7:0] ch                    [2:0] kind        last
// m_axis    out  [63:0] result_value         [1:0] result_type none
//
// One character beat per cycle while the record queue has room.
// The parser commits on each beat, the back pipeline (5 stages) runs the
// 64x20 multiply in two 32-bit halves and rounds the fraction by reciprocal.
// Reset clears parser state, the queue and all stage valids.
// A stall on m_axis freezes the back pipeline; s_axis_tready drops only
// when the record queue is full.
module decimal_time_text_to_microseconds #(
  parameter int unsigned QUEUE_DEPTH = dtt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] kind
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] result_value
  output logic [1:0]       m_axis_tuser    // [1:0] result_type
);
  import dtt_pkg::*;

  logic     accept, push, full, pop, nonempty;
  dtt_rec_t push_rec, head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dtt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (s_axis_tdata),
    .kind   (s_axis_tuser),
    .last   (s_axis_tlast),
    .push   (push),
    .rec    (push_rec)
  );

  dtt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  dtt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_type  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ----- rtl/dtt_front.sv -----
`default_nettype none
module dtt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        ch,
  input  wire logic [2:0]        kind,
  input  wire logic              last,
  output logic                   push,
  output dtt_pkg::dtt_rec_t      rec
);
  import dtt_pkg::*;

  phase_t      phase, phase_next;
  logic        first_minus, first_minus_next;
  logic        whole_neg, whole_neg_next;
  logic [63:0] mag, mag_next;
  logic [29:0] frac, frac_next;
  logic [3:0]  cnt, cnt_next;
  logic        sign_read, sign_read_next;
  logic        tail, tail_next;

  logic        is_blank, is_sign, is_digit, is_dot;
  logic [3:0]  dig;
  logic [63:0] mag_add;
  logic [63:0] mag_lim;

  assign is_blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_dot   = (ch == CH_DOT);
  assign dig      = 4'(ch - CH_ZERO);

  // saturate at 2^63 once the next digit would pass it
  assign mag_lim = (dig == 4'd9) ? SAT_DIV10 - 64'd1 : SAT_DIV10;
  assign mag_add = (mag > mag_lim) ? SAT_LIMIT
                 : (mag << 3) + (mag << 1) + 64'(dig);

  always_comb begin
    phase_next       = phase;
    first_minus_next = first_minus;
    whole_neg_next   = whole_neg;
    mag_next         = mag;
    frac_next        = frac;
    cnt_next         = cnt;
    sign_read_next   = sign_read;
    tail_next        = tail;
    if (!tail) begin
      case (phase)
        PH_START: begin
          first_minus_next = (ch == CH_MINUS);
          if (is_blank) begin
            phase_next = PH_LEAD;
          end else if (is_sign) begin
            sign_read_next = 1'b1;
            whole_neg_next = (ch == CH_MINUS);
            phase_next     = PH_LEAD;
          end else if (is_digit) begin
            mag_next   = mag_add;
            phase_next = PH_WHOLE;
          end else if (is_dot) begin
            phase_next = PH_FRAC;
          end else begin
            tail_next = 1'b1;
          end
        end
        PH_LEAD: begin
          if (is_blank && !sign_read) begin
            phase_next = PH_LEAD;
          end else if (is_sign && !sign_read) begin
            sign_read_next = 1'b1;
            whole_neg_next = (ch == CH_MINUS);
          end else if (is_digit) begin
            mag_next   = mag_add;
            phase_next = PH_WHOLE;
          end else begin
            tail_next = 1'b1;
          end
        end
        PH_WHOLE: begin
          if (is_digit) begin
            mag_next = mag_add;
          end else if (is_dot) begin
            phase_next = PH_FRAC;
          end else begin
            tail_next = 1'b1;
          end
        end
        default: begin
          if (is_digit && cnt < 4'(FRACTION_DIGITS)) begin
            frac_next = 30'((frac << 3) + (frac << 1)) + 30'(dig);
            cnt_next  = cnt + 4'd1;
          end else begin
            tail_next = 1'b1;
          end
        end
      endcase
    end
  end

  assign push = accept && last && (kind <= KIND_TS_ZONE);

  always_comb begin
    rec.mag         = mag_next;
    rec.whole_neg   = whole_neg_next;
    rec.first_minus = first_minus_next;
    rec.frac        = frac_next;
    rec.cnt         = cnt_next;
    rec.kind        = kind;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase       <= PH_START;
      first_minus <= 1'b0;
      whole_neg   <= 1'b0;
      mag         <= '0;
      frac        <= '0;
      cnt         <= '0;
      sign_read   <= 1'b0;
      tail        <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      first_minus <= first_minus_next;
      whole_neg   <= whole_neg_next;
      mag         <= mag_next;
      frac        <= frac_next;
      cnt         <= cnt_next;
      sign_read   <= sign_read_next;
      tail        <= tail_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dtt_queue.sv -----
`default_nettype none
module dtt_queue #(
  parameter int unsigned DEPTH = dtt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dtt_pkg::dtt_rec_t push_rec,
  output logic                   full,
  input  wire logic              pop,
  output logic                   nonempty,
  output dtt_pkg::dtt_rec_t      head
);
  import dtt_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dtt_rec_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dtt_back.sv -----
`default_nettype none
module dtt_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              nonempty,
  input  wire dtt_pkg::dtt_rec_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [63:0]            out_value,
  output logic [1:0]             out_type
);
  import dtt_pkg::*;

  logic        en;
  logic        va, vb, vc, vd;

  logic [63:0] a_whole;
  logic [29:0] a_nanos;
  logic        a_fm;
  logic [2:0]  a_kind;

  logic [63:0] b_base;
  logic [29:0] b_x;
  logic        b_fm;
  logic [2:0]  b_kind;

  logic [51:0] c_prod_lo;
  logic [31:0] c_prod_hi;
  logic [60:0] c_qprod;
  logic [63:0] c_base;
  logic [29:0] c_x;
  logic        c_fm;
  logic [2:0]  c_kind;

  logic [63:0] d_sum;
  logic [63:0] d_micros;
  logic [63:0] d_base;
  logic [2:0]  d_kind;

  logic [63:0] whole_c;
  logic [63:0] shift_c;
  logic [19:0] q0, q1;
  logic [29:0] rem;

  assign en  = !out_valid || out_ready;
  assign pop = en && nonempty;

  assign whole_c = head.whole_neg ? 64'd0 - head.mag
                 : (head.mag[63] ? SAT_LIMIT - 64'd1 : head.mag);

  always_comb begin
    case (a_kind)
      KIND_DATE: shift_c = DAY_SHIFT;
      KIND_TIME: shift_c = '0;
      default:   shift_c = SECOND_SHIFT;
    endcase
  end

  assign q0  = c_qprod[RECIP_SHIFT +: 20];
  assign rem = c_x - 30'(q0) * 30'(THOUSAND);
  assign q1  = (rem >= 30'(THOUSAND)) ? q0 + 20'd1 : q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= nonempty;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_whole   <= whole_c;
      a_nanos   <= 30'(head.frac * pad_scale(head.cnt));
      a_fm      <= head.first_minus;
      a_kind    <= head.kind;

      b_base    <= a_whole - shift_c;
      b_x       <= a_nanos + ROUND_HALF;
      b_fm      <= a_fm;
      b_kind    <= a_kind;

      c_prod_lo <= b_base[31:0] * MICROS_PER_S;
      c_prod_hi <= 32'(b_base[63:32] * MICROS_PER_S);
      c_qprod   <= b_x * RECIP_1000;
      c_base    <= b_base;
      c_x       <= b_x;
      c_fm      <= b_fm;
      c_kind    <= b_kind;

      d_sum     <= 64'(c_prod_lo) + {c_prod_hi, 32'd0};
      d_micros  <= c_fm ? 64'd0 - 64'(q1) : 64'(q1);
      d_base    <= c_base;
      d_kind    <= c_kind;

      out_value <= (d_kind == KIND_DATE) ? d_base : d_sum + d_micros;
      out_type  <= kind_to_type(d_kind);
    end
  end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
  import dtt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_CHARS = 1100;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PERCENT = 26;
  localparam logic [2:0] KIND_MAX = 3'h7;
  localparam logic [63:0] MICROS_PER_SECOND = 64'd1000000;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  rtype;
  } usec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [2:0]  s_axis_tuser = 3'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  usec_result_t pending_results[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  chars_sent = 0;
  logic         steady = 1'b0;

  phase_t      ph;
  logic        first_minus;
  logic        whole_neg;
  logic        sign_seen;
  logic        tail_skip;
  logic [63:0] whole_mag;
  logic [29:0] frac_digits;
  logic [3:0]  frac_count;

  decimal_time_text_to_microseconds dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function void clear_parser();
    ph = PH_START;
    first_minus = 1'b0;
    whole_neg = 1'b0;
    sign_seen = 1'b0;
    tail_skip = 1'b0;
    whole_mag = 64'd0;
    frac_digits = 30'd0;
    frac_count = 4'd0;
  endfunction

  function void add_whole_digit(input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - CH_ZERO};
    if (whole_mag > (SAT_LIMIT - d) / 64'd10)
      whole_mag = SAT_LIMIT;
    else
      whole_mag = whole_mag * 64'd10 + d;
  endfunction

  function void parse_char(input logic [7:0] c);
    if (tail_skip)
      return;
    case (ph)
      PH_START: begin
        first_minus = (c == CH_MINUS);
        if (is_blank(c)) begin
          ph = PH_LEAD;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          sign_seen = 1'b1;
          whole_neg = (c == CH_MINUS);
          ph = PH_LEAD;
        end else if (is_digit(c)) begin
          add_whole_digit(c);
          ph = PH_WHOLE;
        end else if (c == CH_DOT) begin
          ph = PH_FRAC;
        end else begin
          tail_skip = 1'b1;
        end
      end
      PH_LEAD: begin
        if (is_blank(c) && !sign_seen) begin
          ph = PH_LEAD;
        end else if ((c == CH_PLUS || c == CH_MINUS) && !sign_seen) begin
          sign_seen = 1'b1;
          whole_neg = (c == CH_MINUS);
        end else if (is_digit(c)) begin
          add_whole_digit(c);
          ph = PH_WHOLE;
        end else begin
          tail_skip = 1'b1;
        end
      end
      PH_WHOLE: begin
        if (is_digit(c))
          add_whole_digit(c);
        else if (c == CH_DOT)
          ph = PH_FRAC;
        else
          tail_skip = 1'b1;
      end
      default: begin
        if (is_digit(c) && frac_count < FRACTION_DIGITS) begin
          frac_digits = frac_digits * 30'd10 + {22'd0, c - CH_ZERO};
          frac_count = frac_count + 4'd1;
        end else begin
          tail_skip = 1'b1;
        end
      end
    endcase
  endfunction

  function void finish_value(input logic [2:0] kind);
    logic [63:0] whole;
    logic [63:0] nanos;
    logic [63:0] micros;
    usec_result_t r;
    if (whole_neg)
      whole = 64'd0 - whole_mag;
    else
      whole = (whole_mag >= SAT_LIMIT) ? SAT_LIMIT - 64'd1 : whole_mag;
    nanos = {34'd0, frac_digits};
    for (int i = frac_count; i < FRACTION_DIGITS; i++)
      nanos = nanos * 64'd10;
    micros = (nanos + 64'd500) / 64'd1000;
    if (first_minus)
      micros = 64'd0 - micros;
    clear_parser();
    case (kind)
      KIND_DATE: begin
        r.value = whole - DAY_SHIFT;
        r.rtype = TYPE_DATE;
      end
      KIND_TIME: begin
        r.value = whole * MICROS_PER_SECOND + micros;
        r.rtype = TYPE_TIME;
      end
      KIND_TS: begin
        r.value = (whole - SECOND_SHIFT) * MICROS_PER_SECOND + micros;
        r.rtype = TYPE_TS;
      end
      KIND_TS_LOCAL, KIND_TS_ZONE: begin
        r.value = (whole - SECOND_SHIFT) * MICROS_PER_SECOND + micros;
        r.rtype = TYPE_TS_TZ;
      end
      default: return;
    endcase
    pending_results.push_back(r);
  endfunction

  initial clear_parser();

  // predict on each accepted input beat, then check each accepted result beat
  always @(posedge clk) begin
    usec_result_t want;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      parse_char(s_axis_tdata);
      if (s_axis_tlast)
        finish_value(s_axis_tuser);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got value %0d type %0d",
                 $time, $signed(m_axis_tdata), m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value) begin
          $display("%0t result_value mismatch: expected %0d, got %0d",
                   $time, $signed(want.value), $signed(m_axis_tdata));
          errors++;
        end
        if (m_axis_tuser !== want.rtype) begin
          $display("%0t result_type mismatch: expected %0d, got %0d",
                   $time, want.rtype, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk)
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic [2:0] kind, input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= kind;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic [2:0] kind);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], kind, i == s.len() - 1);
  endtask

  task automatic test_each_kind();
    for (int k = 0; k <= KIND_MAX; k++)
      send_text(string'(8'(CH_ZERO + k)), 3'(k));
  endtask

  task automatic test_signs_and_blanks();
    send_text(" -7", KIND_TIME);
    send_text("+-2", KIND_TIME);
    send_text("\t.5", KIND_TS);
    send_text("-", KIND_DATE);
  endtask

  task automatic test_fraction_and_extremes();
    send_text(".5", KIND_TIME);
    send_text(".0000005", KIND_TS_LOCAL);
    send_char(8'hFF, KIND_TS_ZONE, 1'b1);
    send_char(8'h00, KIND_DATE, 1'b1);
  endtask

  task automatic push_text(ref logic [7:0] txt[$], input string s);
    for (int i = 0; i < s.len(); i++)
      txt.push_back(s[i]);
  endtask

  task automatic test_random_text();
    logic [7:0] txt[$];
    logic [2:0] kind;
    int         n;
    int         pick;
    while (chars_sent < RANDOM_CHARS + 40) begin
      txt.delete();
      steady = (chars_sent > 400 && chars_sent < 650);
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          pick = $urandom_range(0, 5);
          case (pick)
            0: txt.push_back(CH_DOT);
            1: txt.push_back(CH_PLUS);
            2: txt.push_back(CH_MINUS);
            3: txt.push_back(CH_SPACE);
            4: txt.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            default: txt.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 2);
          repeat (n)
            txt.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE :
                          8'($urandom_range(CH_TAB, CH_CR)));
        end
        pick = $urandom_range(0, 3);
        if (pick == 0)
          txt.push_back(CH_PLUS);
        else if (pick == 1)
          txt.push_back(CH_MINUS);
        pick = $urandom_range(0, 15);
        if (pick == 1) begin
          n = $urandom_range(19, 21);
          repeat (n)
            txt.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end else if (pick == 2) begin
          case ($urandom_range(0, 2))
            0: push_text(txt, "9223372036854775807");
            1: push_text(txt, "9223372036854775808");
            default: push_text(txt, "9223372036854775809");
          endcase
        end else if (pick != 0) begin
          n = $urandom_range(1, 10);
          repeat (n)
            txt.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(0, 3) != 0) begin
          txt.push_back(CH_DOT);
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 11) : $urandom_range(0, 9);
          repeat (n)
            txt.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        pick = $urandom_range(0, 5);
        if (pick == 0)
          push_text(txt, "+05:30");
        else if (pick == 1)
          txt.push_back(8'($urandom_range(0, 255)));
      end
      if (txt.size() == 0)
        txt.push_back(8'($urandom_range(0, 255)));
      kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(KIND_TS_ZONE + 1, KIND_MAX)) :
             3'($urandom_range(KIND_DATE, KIND_TS_ZONE));
      for (int i = 0; i < txt.size(); i++) begin
        if (i == txt.size() - 1)
          send_char(txt[i], kind, 1'b1);
        else
          send_char(txt[i], 3'($urandom_range(0, KIND_MAX)), 1'b0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_each_kind();
    test_signs_and_blanks();
    test_fraction_and_extremes();
    test_random_text();
    // drop valid on the step of the final accepted beat
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dtt_pkg.sv
rtl/dtt_front.sv
rtl/dtt_queue.sv
rtl/dtt_back.sv
rtl/decimal_time_text_to_microseconds.sv
dv/testbench.sv
